FILE: src/ilst_pkg.sv
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared types and codes for the indexed list store: command and status
// codes, and the control word broadcast along the row of entry cells.
// ----------------------------------------------------------------------------
package ilst_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_LOOKUP = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic     en;     // a word was accepted this cycle
        t_cell_op op;
        logic     rd_en;  // one cell presents its entry on its tap
    } t_cell_ctl;

endpackage

FILE: src/indexed_list_store_top.sv
// ----------------------------------------------------------------------------
// Pipeline: an accepted command word passes stage 1 and then the output register.
// Throughput: one command word per cycle while o_stall is low; every cell of
//   the row registers its next entry and tap on acceptance, and the tap OR is registered when stage 1 moves on.
// Reset (synchronous, active low): count to zero, pipeline empty. Entries are
//   not cleared: only entries below the count are ever read.
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Ordered list of signed 32-bit words held in a row of cells, one cell per
// entry. Push, pop, insert, remove, lookup and clear each return a word,
// a status and the new count.
// ----------------------------------------------------------------------------
module indexed_list_store_top
    import ilst_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_command,
    input  logic [6:0]         i_position,
    input  logic signed [31:0] i_word_in,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_word_out,
    output logic [1:0]         o_status,
    output logic [6:0]         o_entry_count
);

    // count needs to hold DEPTH itself; indexes are compared at a width that
    // covers both the count and the 7-bit position field
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    // stage 1: status and count, taps inside the cells
    logic            r_s1_valid;
    t_status         r_s1_status;
    logic [6:0]      r_s1_count;

    // output register
    logic            r_out_valid;
    logic [31:0]     r_word_out;
    t_status         r_status;
    logic [6:0]      r_count_out;

    logic            in_acc;
    logic            s1_adv;

    t_cell_ctl       ctl;
    t_status         dec_status;
    logic [CMPW-1:0] tgt;
    logic [CMPW-1:0] rd_idx;
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic            full;

    logic [31:0]     cell_data [DEPTH];
    logic [31:0]     cell_tap  [DEPTH];
    logic [31:0]     tap_or;

    // ---- handshake -------------------------------------------------------
    // stage 1 moves on when the output register is free or being drained
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    // ---- command decode --------------------------------------------------
    assign pos_x = CMPW'(i_position);
    assign cnt_x = CMPW'(r_count);
    assign full  = (r_count == CW'(DEPTH));

    always_comb begin
        ctl.en     = in_acc;
        ctl.op     = OP_HOLD;
        ctl.rd_en  = 1'b0;
        tgt        = pos_x;
        rd_idx     = pos_x;
        dec_status = ST_OK;
        n_count    = r_count;
        unique case (i_command)
            CMD_PUSH: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    // a push is an insert at the end of the list
                    ctl.op  = OP_INSERT;
                    tgt     = cnt_x;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    dec_status = ST_EMPTY;
                end else begin
                    ctl.rd_en = 1'b1;
                    rd_idx    = cnt_x - CMPW'(1);
                    n_count   = r_count - CW'(1);
                end
            end
            CMD_INSERT: begin
                // range is checked before full
                if (pos_x > cnt_x) begin
                    dec_status = ST_RANGE;
                end else if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    ctl.op  = OP_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_REMOVE: begin
                if (pos_x >= cnt_x) begin
                    dec_status = ST_RANGE;
                end else begin
                    ctl.op    = OP_REMOVE;
                    ctl.rd_en = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            CMD_LOOKUP: begin
                if (pos_x >= cnt_x) begin
                    dec_status = ST_RANGE;
                end else begin
                    ctl.rd_en = 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unused codes leave everything as it is and answer ok
                n_count = r_count;
            end
        endcase
    end

    // ---- row of cells ----------------------------------------------------
    // cell 0 has no lower neighbour and the top cell no upper one; those
    // inputs are never selected for the entries that matter
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [31:0] lower;
        logic [31:0] upper;

        if (g == 0) begin : g_first
            assign lower = i_word_in;
        end else begin : g_mid_lo
            assign lower = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign upper = cell_data[g];
        end else begin : g_mid_hi
            assign upper = cell_data[g+1];
        end

        ilst_cell #(
            .IDX_W (CMPW),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_tgt   (tgt),
            .i_rd    (rd_idx),
            .i_word  (i_word_in),
            .i_lower (lower),
            .i_upper (upper),
            .o_data  (cell_data[g]),
            .o_tap   (cell_tap[g])
        );
    end

    // only the addressed cell drives a non-zero tap
    always_comb begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tap_or = tap_or | cell_tap[k];
        end
    end

    // ---- count and pipeline registers ------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count    <= n_count;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status <= dec_status;
            r_s1_count  <= 7'(n_count);
        end
        if (s1_adv) begin
            r_word_out  <= tap_or;
            r_status    <= r_s1_status;
            r_count_out <= r_s1_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_word_out    = r_word_out;
    assign o_status      = r_status;
    assign o_entry_count = r_count_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above store depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command == CMD_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the list");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command == CMD_PUSH && !full) |=>
        (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the list by one");

    a_no_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_stall)
        else $error("input stalled with an empty pipeline");
`endif

endmodule

FILE: src/ilst_cell.sv
// ----------------------------------------------------------------------------
// ilst_cell
// One entry of the list. Takes the broadcast word, its lower neighbour or
// its upper neighbour, and registers its old entry on the tap when read.
// ----------------------------------------------------------------------------
module ilst_cell
    import ilst_pkg::*;
#(
    parameter int IDX_W = 7,
    parameter int IDX   = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [IDX_W-1:0]  i_tgt,
    input  logic [IDX_W-1:0]  i_rd,
    input  logic [31:0]       i_word,
    input  logic [31:0]       i_lower,
    input  logic [31:0]       i_upper,
    output logic [31:0]       o_data,
    output logic [31:0]       o_tap
);

    localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

    logic [31:0] r_data;
    logic [31:0] n_data;
    logic [31:0] r_tap;
    logic [31:0] n_tap;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            OP_INSERT: begin
                if (MyIdx == i_tgt) begin
                    n_data = i_word;
                end else if (MyIdx > i_tgt) begin
                    n_data = i_lower;
                end
            end
            OP_REMOVE: begin
                if (MyIdx >= i_tgt) begin
                    n_data = i_upper;
                end
            end
            default: n_data = r_data;
        endcase
        n_tap = (i_ctl.rd_en && (MyIdx == i_rd)) ? r_data : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_data <= n_data;
            r_tap  <= n_tap;
        end
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

FILE: dv/indexed_list_store_top_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_store_top_tb
// Self-checking bench for the indexed list store. A behavioural copy of the
// list predicts every result word as each command word is accepted, and a
// checker compares the block's result words against them in order. Directed
// tests cover the empty list, the basic edits and the full store. A pressure
// test holds the result channel off so that the block fills up. A long
// random mix then sweeps the count between empty and full under random gaps
// on both channels.
// ----------------------------------------------------------------------------
module indexed_list_store_top_tb;
    import ilst_pkg::*;

    localparam int LIST_DEPTH   = 64;
    localparam int CYCLE_LIMIT  = 400000;  // well above the slowest legal run
    localparam int SETTLE_SLACK = 8;       // leave a margin over the pipeline

    // codes 6 and 7 are not commands; the block must ignore them
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // mix of commands in the random test
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_STEADY
    } t_mix;

    // one expected result word
    typedef struct {
        logic signed [31:0] word;
        t_status            status;
        logic [6:0]         count;
    } t_list_reply;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic [2:0]         i_command     = '0;
    logic [6:0]         i_position    = '0;
    logic signed [31:0] i_word_in     = '0;
    logic               i_stall       = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic signed [31:0] o_word_out;
    logic [1:0]         o_status;
    logic [6:0]         o_entry_count;

    // behavioural copy of the list
    logic signed [31:0] list_mem [LIST_DEPTH];
    int                 list_len = 0;

    t_list_reply        pending_replies [$];
    int                 fail_count  = 0;
    int                 cycle_count = 0;

    // idling control set by the test tasks, and the receiver process's stall run state
    bit                 calm_sender   = 1'b0;
    bit                 calm_receiver = 1'b0;
    int                 hold_cycles   = 0;
    int                 stall_run     = 0;
    bit                 stall_level   = 1'b0;

    indexed_list_store_top #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_position    (i_position),
        .i_word_in     (i_word_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_word_out    (o_word_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Gap length: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 50);
    endfunction

    // Applies one command to the behavioural list and returns its result.
    // Errors leave the list and the count untouched.
    function automatic t_list_reply apply_list_command(
        input logic [2:0]         cmd,
        input logic [6:0]         pos,
        input logic signed [31:0] data
    );
        t_list_reply rep;
        rep.word   = '0;
        rep.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (list_len >= LIST_DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    list_mem[list_len] = data;
                    list_len++;
                end
            end
            CMD_POP: begin
                if (list_len == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    list_len--;
                    rep.word = list_mem[list_len];
                end
            end
            CMD_INSERT: begin
                // range is checked before full
                if (int'(pos) > list_len) begin
                    rep.status = ST_RANGE;
                end else if (list_len >= LIST_DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > int'(pos); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = data;
                    list_len++;
                end
            end
            CMD_REMOVE: begin
                if (int'(pos) >= list_len) begin
                    rep.status = ST_RANGE;
                end else begin
                    rep.word = list_mem[pos];
                    for (int i = int'(pos); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            CMD_LOOKUP: begin
                if (int'(pos) >= list_len) begin
                    rep.status = ST_RANGE;
                end else begin
                    rep.word = list_mem[pos];
                end
            end
            CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
                // spare codes: no change, plain ok
            end
        endcase
        rep.count = list_len[6:0];
        return rep;
    endfunction

    // Offers one command word and holds it until accepted. Valid is left high
    // when no gap follows, so back-to-back words never toggle it in one step.
    task automatic send_word(
        input logic [2:0]         cmd,
        input logic [6:0]         pos,
        input logic signed [31:0] data
    );
        int gap;
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_position <= pos;
        i_word_in  <= data;
        do
            @(posedge i_clk);
        while (o_stall);
        pending_replies.push_back(apply_list_command(cmd, pos, data));
        gap = (calm_sender || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender pauses until every expected result word is back. Always waits
    // on the clock first, so the next word is offered in a later step.
    task automatic drain_replies();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_replies.size() != 0);
    endtask

    // Every lookup, remove and pop on an empty list is an error; spare codes
    // and clear are harmless.
    task automatic test_empty_list();
        send_word(CMD_POP,      7'd0,   32'sd11);
        send_word(CMD_LOOKUP,   7'd0,   32'sd0);
        send_word(CMD_REMOVE,   7'd0,   32'sd0);
        send_word(CMD_INSERT,   7'd1,   32'sd99);   // past the count
        send_word(CMD_LOOKUP,   7'd127, 32'sd0);
        send_word(CMD_SPARE_LO, 7'd0,   -32'sd1);
        send_word(CMD_SPARE_HI, 7'd127, 32'sd5);
        send_word(CMD_CLEAR,    7'd0,   32'sd0);
    endtask

    // Word extremes, inserts at head, tail and middle, removes at each end.
    task automatic test_basic_edits();
        send_word(CMD_PUSH,   7'd0,   32'sh8000_0000);
        send_word(CMD_PUSH,   7'd127, 32'sh7fff_ffff);
        send_word(CMD_PUSH,   7'd0,   32'sd0);
        send_word(CMD_PUSH,   7'd0,   -32'sd1);
        send_word(CMD_INSERT, 7'd0,   32'sd5);
        send_word(CMD_INSERT, 7'd5,   32'sh1234_5678);  // at count: appends
        send_word(CMD_INSERT, 7'd2,   -32'sd7);
        for (int i = 0; i < 7; i++)
            send_word(CMD_LOOKUP, 7'(i), 32'sd0);
        send_word(CMD_REMOVE, 7'd0,   32'sd0);
        send_word(CMD_REMOVE, 7'd5,   32'sd0);          // last entry
        send_word(CMD_REMOVE, 7'd2,   32'sd0);
        send_word(CMD_POP,    7'd0,   32'sd0);
        send_word(CMD_CLEAR,  7'd3,   32'sd1);
        send_word(CMD_POP,    7'd0,   32'sd0);
    endtask

    // Fill to the top, then the full and range errors at the boundary.
    task automatic test_full_store();
        send_word(CMD_CLEAR, 7'd0, 32'sd0);
        while (list_len < LIST_DEPTH) begin
            if ($urandom_range(0, 1))
                send_word(CMD_PUSH, 7'($urandom_range(0, 127)), $urandom);
            else
                send_word(CMD_INSERT, 7'($urandom_range(0, list_len)), $urandom);
        end
        send_word(CMD_PUSH,   7'd0,              $urandom);
        send_word(CMD_INSERT, 7'd10,             $urandom);
        send_word(CMD_INSERT, 7'(LIST_DEPTH),    $urandom);
        send_word(CMD_INSERT, 7'(LIST_DEPTH + 1), $urandom);
        send_word(CMD_LOOKUP, 7'(LIST_DEPTH - 1), 32'sd0);
        send_word(CMD_LOOKUP, 7'(LIST_DEPTH),    32'sd0);
        send_word(CMD_REMOVE, 7'(LIST_DEPTH - 1), 32'sd0);
        send_word(CMD_REMOVE, 7'd0,              32'sd0);
        send_word(CMD_INSERT, 7'd0,              $urandom);
        send_word(CMD_POP,    7'd0,              32'sd0);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // words back to back, so the block backs up into its command channel.
    task automatic test_backpressure();
        calm_sender = 1'b1;
        hold_cycles = 200;
        for (int i = 0; i < 30; i++)
            send_word(($urandom_range(0, 3) == 0) ? CMD_LOOKUP : CMD_PUSH,
                      7'($urandom_range(0, 3)), $urandom);
        calm_sender = 1'b0;
    endtask

    function automatic logic [2:0] pick_command(input t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return r[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
        if (r < 3)
            return CMD_CLEAR;
        case (mix)
            MIX_GROW:   return (r < 40) ? CMD_PUSH : (r < 65) ? CMD_INSERT :
                               (r < 80) ? CMD_LOOKUP : (r < 90) ? CMD_REMOVE : CMD_POP;
            MIX_SHRINK: return (r < 35) ? CMD_POP : (r < 65) ? CMD_REMOVE :
                               (r < 80) ? CMD_LOOKUP : (r < 90) ? CMD_PUSH : CMD_INSERT;
            default:    return (r < 22) ? CMD_PUSH : (r < 42) ? CMD_INSERT :
                               (r < 62) ? CMD_LOOKUP : (r < 82) ? CMD_REMOVE : CMD_POP;
        endcase
    endfunction

    // Mostly a legal index for the current count, with edges and noise.
    function automatic logic [6:0] pick_position(input logic [2:0] cmd);
        int r;
        int top;
        r   = $urandom_range(0, 99);
        top = (cmd == CMD_INSERT) ? list_len : ((list_len > 0) ? list_len - 1 : 0);
        if (r < 10)
            return 7'($urandom_range(0, 127));
        if (r < 18)
            return 7'd0;
        if (r < 26)
            return 7'(top);
        return 7'($urandom_range(0, top));
    endfunction

    function automatic logic signed [31:0] pick_data();
        case ($urandom_range(0, 19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Epochs of growing, shrinking or steady mixes; each epoch also picks
    // whether either side idles, so there are stretches at full rate.
    task automatic test_random_mix(input int n_words);
        t_mix       mix;
        logic [2:0] cmd;
        mix = MIX_GROW;
        for (int i = 0; i < n_words; i++) begin
            if (i % 75 == 0) begin
                if (list_len > 52)
                    mix = MIX_SHRINK;
                else if (list_len < 8)
                    mix = MIX_GROW;
                else
                    mix = t_mix'($urandom_range(0, 2));
                calm_sender   = ($urandom_range(0, 3) == 0);
                calm_receiver = ($urandom_range(0, 3) == 0);
            end
            cmd = pick_command(mix);
            send_word(cmd, pick_position(cmd), pick_data());
        end
        calm_sender   = 1'b0;
        calm_receiver = 1'b0;
    endtask

    // Result channel stall: a long hold when a test asks for one, else runs
    // of random length with and without stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else if (calm_receiver) begin
            i_stall   <= 1'b0;
            stall_run = 0;
        end else begin
            if (stall_run == 0) begin
                stall_level = ($urandom_range(0, 2) == 0);
                stall_run   = pick_gap();
            end
            i_stall <= stall_level;
            stall_run--;
        end
    end

    // Each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_list_reply exp_rep;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_replies.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                exp_rep = pending_replies.pop_front();
                if (o_word_out !== exp_rep.word) begin
                    $error("word_out: expected %0d, got %0d", exp_rep.word, o_word_out);
                    fail_count++;
                end
                if (o_status !== exp_rep.status) begin
                    $error("status: expected %0d, got %0d", exp_rep.status, o_status);
                    fail_count++;
                end
                if (o_entry_count !== exp_rep.count) begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_rep.count, o_entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("indexed_list_store_top verification failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        drain_replies();
        test_basic_edits();
        drain_replies();
        test_full_store();
        drain_replies();
        test_backpressure();
        drain_replies();
        test_random_mix(620);
        drain_replies();

        // anything still in flight would show up here as an unexpected word
        repeat (SETTLE_SLACK) @(posedge i_clk);
        if (fail_count == 0 && pending_replies.size() == 0) begin
            $display("indexed_list_store_top verification clean");
        end else begin
            $display("indexed_list_store_top verification failed");
        end
        $finish;
    end

endmodule
